### rtl/core/floyd_steinberg_dither_3bit_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3-bit error-diffusion dither core
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef FLOYD_STEINBERG_DITHER_3BIT_CORE_DEFINES_SVH
`define FLOYD_STEINBERG_DITHER_3BIT_CORE_DEFINES_SVH

// Check that is switched off while reset is held.
`define FSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset.
`define FSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Types, register indexes and luma constants of the 3-bit dither core.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } fsd_in_t;

  typedef struct packed {
    logic [2:0] level;
    logic       end_of_row;
    logic       end_of_frame;
  } fsd_out_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 2'd3;

  localparam logic [10:0] ROW_WIDTH_RST    = 11'd800;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd600;

  // Division by 10000 is done as a multiply by a rounded-up reciprocal.
  // The error term times the largest weighted byte stays far below 2^35,
  // so the truncated quotient is exact.
  localparam int          LUMA_SHIFT = 35;
  localparam longint      LUMA_DIV   = 10000;
  localparam longint      LUMA_RECIP = ((64'd1 << LUMA_SHIFT) + LUMA_DIV - 1) / LUMA_DIV;
  localparam logic [34:0] LUMA_K0    = 35'(2126 * LUMA_RECIP);
  localparam logic [34:0] LUMA_K1    = 35'(7152 * LUMA_RECIP);
  localparam logic [34:0] LUMA_K2    = 35'(722 * LUMA_RECIP);

  function automatic logic [7:0] luma_term(input logic [7:0] c, input logic [34:0] k);
    logic [42:0] p;
    p = 43'(c) * 43'(k);
    return p[42:35];
  endfunction

  // The three truncated terms never add past 254.
  function automatic logic [7:0] luma(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2);
    logic [9:0] s;
    s = 10'(luma_term(b0, LUMA_K0)) + 10'(luma_term(b1, LUMA_K1))
      + 10'(luma_term(b2, LUMA_K2));
    return s[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/floyd_steinberg_dither_3bit_core.sv
// Pipeline: the accepting edge reads the error memory into the diffusion stage
// registers, and the edge that fires the diffusion step loads the output
// register; a stalled output holds the beat in the diffusion stage.
// Throughput: one pixel per cycle unless the output stalls, set by the
// right-carry loop and one read plus one write of the next-row error memory per cycle.
// Reset: synchronous; counters, carries and config go to defaults, and the
// error memory is not cleared, since row 0 never reads it.
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_3bit_core
// Raster-order error-diffusion dither of gray or RGB pixels to 3-bit levels.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_dither_3bit_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fsd_pkg::fsd_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fsd_pkg::fsd_out_t                   out_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > 11) ? WW : 11;

  // Configuration
  logic [10:0] row_width_r;
  logic [11:0] frame_height_r;
  logic        pixel_format_r;
  logic        invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= fsd_pkg::ROW_WIDTH_RST;
      frame_height_r <= fsd_pkg::FRAME_HEIGHT_RST;
      pixel_format_r <= 1'b0;
      invert_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsd_pkg::REG_ROW_WIDTH:    row_width_r    <= cfg_data[10:0];
        fsd_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[11:0];
        fsd_pkg::REG_PIXEL_FORMAT: pixel_format_r <= cfg_data[0];
        fsd_pkg::REG_INVERT:       invert_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accept stage: position in the frame and gray conversion
  logic          in_acc;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] col_ext;
  logic [AW-1:0] col;
  logic          last_col;
  logic [11:0]   h_eff;
  logic          last_row;
  logic [7:0]    b0, b1, b2, gray;

  logic [AW-1:0] col_cnt_r, col_cnt_nxt;
  logic [11:0]   row_cnt_r, row_cnt_nxt;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    if (row_width_r == 11'd0) begin
      w_eff = CW'(1);
    end else if (CW'(row_width_r) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(row_width_r);
    end
    // A count left past the width by a register change ends the row.
    col_ext = CW'(col_cnt_r);
    if (col_ext >= w_eff) begin
      col_ext = w_eff - CW'(1);
    end
    col      = col_ext[AW-1:0];
    last_col = CW'(col_ext + CW'(1)) >= w_eff;
    h_eff    = (frame_height_r == 12'd0) ? 12'd1 : frame_height_r;
    last_row = (13'(row_cnt_r) + 13'd1) >= 13'(h_eff);
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? 12'd0 : 12'(row_cnt_r + 12'd1);
      end else begin
        col_cnt_nxt = AW'(col + AW'(1));
      end
    end
  end

  always_comb begin
    b0   = invert_r ? ~in_data.byte0 : in_data.byte0;
    b1   = invert_r ? ~in_data.byte1 : in_data.byte1;
    b2   = invert_r ? ~in_data.byte2 : in_data.byte2;
    gray = pixel_format_r ? fsd_pkg::luma(b0, b1, b2) : b0;
  end

  // Diffusion stage registers
  logic          s1_v_r, s1_v_nxt;
  logic [7:0]    s1_gray_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_last_col_r;
  logic          s1_last_row_r;
  logic          s1_row0_r;
  logic          fwd_hit_r;
  logic [3:0]    fwd_data_r;
  logic [3:0]    mem_q_r;
  logic          s1_fire;

  logic          out_v_r, out_v_nxt;
  fsd_pkg::fsd_out_t out_data_r;

  assign s1_fire  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_fire;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  // Diffusion step
  logic [3:0] rc_r, rc_nxt;
  logic [3:0] pl_r, pl_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic [3:0] down;
  logic [8:0] sum;
  logic [7:0] adj;
  logic [4:0] err;
  logic [7:0] e7w, e5w;
  logic [6:0] e3w;
  logic [3:0] dl_data;
  logic [3:0] pl_calc;

  always_comb begin
    if (s1_row0_r) begin
      down = 4'd0;
    end else begin
      down = fwd_hit_r ? fwd_data_r : mem_q_r;
    end
    sum     = 9'(s1_gray_r) + 9'(down) + 9'(rc_r);
    adj     = sum[8] ? 8'hFF : sum[7:0];
    err     = adj[4:0];
    e7w     = 8'(err) * 8'd7;
    e5w     = 8'(err) * 8'd5;
    e3w     = 7'(err) * 7'd3;
    dl_data = 4'(pl_r + 4'(e3w[6:4]));
    pl_calc = 4'(ph_r + e5w[7:4]);
  end

  always_comb begin
    rc_nxt = rc_r;
    pl_nxt = pl_r;
    ph_nxt = ph_r;
    if (s1_fire) begin
      if (s1_last_col_r) begin
        rc_nxt = 4'd0;
        pl_nxt = 4'd0;
        ph_nxt = 4'd0;
      end else begin
        rc_nxt = e7w[7:4];
        if (!s1_last_row_r) begin
          pl_nxt = pl_calc;
          ph_nxt = {3'd0, err[4]};
        end
      end
    end
  end

  // Error memory traffic. The down-left share is written at once; the last
  // column's own entry is held in a register and written in the cycle after, a
  // slot that is free because the next pixel sits in column zero and writes nothing.
  logic          s1_wr;
  logic          def_set;
  logic          def_v_r;
  logic [AW-1:0] def_addr_r;
  logic [3:0]    def_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_data;
  logic          fwd_hit_nxt;
  logic [3:0]    fwd_data_nxt;

  assign s1_wr   = s1_fire && !s1_last_row_r && (s1_col_r != '0);
  assign def_set = s1_fire && s1_last_col_r && !s1_last_row_r;
  assign wr_en   = s1_wr || def_v_r;
  assign wr_addr = s1_wr ? AW'(s1_col_r - AW'(1)) : def_addr_r;
  assign wr_data = s1_wr ? dl_data : def_data_r;

  // A read in the same cycle as a write or deferral of its entry takes the new data.
  always_comb begin
    fwd_hit_nxt  = 1'b0;
    fwd_data_nxt = wr_data;
    priority if (def_set && (s1_col_r == col)) begin
      fwd_hit_nxt  = 1'b1;
      fwd_data_nxt = pl_calc;
    end else if (wr_en && (wr_addr == col)) begin
      fwd_hit_nxt  = 1'b1;
      fwd_data_nxt = wr_data;
    end else begin
      fwd_hit_nxt  = 1'b0;
    end
  end

  logic [3:0] err_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      err_mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      mem_q_r <= err_mem[col];
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      def_v_r   <= 1'b0;
      rc_r      <= 4'd0;
      pl_r      <= 4'd0;
      ph_r      <= 4'd0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
      def_v_r   <= def_set;
      rc_r      <= rc_nxt;
      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gray_r     <= gray;
      s1_col_r      <= col;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      s1_row0_r     <= (row_cnt_r == 12'd0);
      fwd_hit_r     <= fwd_hit_nxt;
      fwd_data_r    <= fwd_data_nxt;
    end
    if (def_set) begin
      def_addr_r <= s1_col_r;
      def_data_r <= pl_calc;
    end
    if (s1_fire) begin
      out_data_r.level        <= adj[7:5];
      out_data_r.end_of_row   <= s1_last_col_r;
      out_data_r.end_of_frame <= s1_last_col_r && s1_last_row_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the dither core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "floyd_steinberg_dither_3bit_core_defines.svh"

module fsd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input fsd_pkg::fsd_out_t out_data
);

  // A pending result beat is not withdrawn while the sink stalls.
  `FSD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")

  // The diffusion stage drains whenever the output register is empty.
  `FSD_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty output")

  // The frame ends only on the last pixel of a row.
  `FSD_ASSERT(a_eof_eor, out_valid && out_data.end_of_frame |-> out_data.end_of_row,
              "end of frame without end of row")

  // Reset empties the output register.
  `FSD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind floyd_steinberg_dither_3bit_core fsd_checker u_fsd_checker (.*);

`default_nettype wire

### test/floyd_steinberg_dither_3bit_core_tb.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_3bit_core_tb
// Self-checking bench for the 3-bit error-diffusion dither core. It streams
// gray and RGB pixels through a series of row widths, frame heights and
// polarities, including mid-row shrinks, and compares every output beat with
// the levels and row and frame flags that a built-in predictor works out.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither_3bit_core_tb;

  localparam int          MAX_W       = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class dither_checker;
    logic [10:0]         row_width;
    logic [11:0]         frame_height;
    bit                  pix_rgb;
    bit                  inv_px;
    logic [3:0]          row_errs [MAX_W];
    int unsigned         col;
    int unsigned         row;
    int unsigned         carry;
    int unsigned         pend_left;
    int unsigned         pend_here;
    fsd_pkg::fsd_out_t   levels_due [$];
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      row_width    = fsd_pkg::ROW_WIDTH_RST;
      frame_height = fsd_pkg::FRAME_HEIGHT_RST;
      pix_rgb      = 1'b0;
      inv_px       = 1'b0;
      for (int i = 0; i < MAX_W; i++) row_errs[i] = 4'd0;
      col        = 0;
      row        = 0;
      carry      = 0;
      pend_left  = 0;
      pend_here  = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [fsd_pkg::CFG_IDX_W-1:0] idx,
                            logic [fsd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        fsd_pkg::REG_ROW_WIDTH:    row_width = val[10:0];
        fsd_pkg::REG_FRAME_HEIGHT: frame_height = val[11:0];
        fsd_pkg::REG_PIXEL_FORMAT: pix_rgb = val[0];
        fsd_pkg::REG_INVERT:       inv_px = val[0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction

    function int unsigned gray_of(fsd_pkg::fsd_in_t px);
      int unsigned b0, b1, b2;
      b0 = px.byte0;
      b1 = px.byte1;
      b2 = px.byte2;
      if (inv_px) begin
        b0 = 255 - b0;
        b1 = 255 - b1;
        b2 = 255 - b2;
      end
      if (!pix_rgb) return b0;
      return b0 * 2126 / 10000 + b1 * 7152 / 10000 + b2 * 722 / 10000;
    endfunction

    // Quantizes one pixel and spreads its remainder to the right and the row below.
    function void take_pixel(fsd_pkg::fsd_in_t px);
      int unsigned       w, h, c, down, adj, e;
      bit                last_col, last_row;
      fsd_pkg::fsd_out_t lvl;
      w = row_width;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      h = frame_height;
      if (h == 0) h = 1;
      c = col;
      if (c >= w) c = w - 1;
      last_col = (c + 1 >= w);
      last_row = (row + 1 >= h);
      down = (row == 0) ? 0 : row_errs[c];
      adj = gray_of(px) + down + carry;
      if (adj > 255) adj = 255;
      e = adj & 31;
      carry = last_col ? 0 : ((e * 7) >> 4);
      if (!last_row) begin
        if (c >= 1) row_errs[c-1] = 4'((pend_left + ((e * 3) >> 4)) & 15);
        pend_left = (pend_here + ((e * 5) >> 4)) & 15;
        pend_here = last_col ? 0 : (e >> 4);
        if (last_col) row_errs[c] = 4'(pend_left);
      end
      lvl.level        = 3'((adj >> 5) & 7);
      lvl.end_of_row   = last_col;
      lvl.end_of_frame = last_col && last_row;
      levels_due.push_back(lvl);
      if (last_col) begin
        col       = 0;
        carry     = 0;
        pend_left = 0;
        pend_here = 0;
        row       = last_row ? 0 : ((row + 1) & 12'hFFF);
      end else begin
        col = c + 1;
      end
    endfunction

    function void match_level(fsd_pkg::fsd_out_t got);
      fsd_pkg::fsd_out_t want;
      if (levels_due.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: output beat with nothing pending: level %0d eor %0b eof %0b",
                   got.level, got.end_of_row, got.end_of_frame);
        mismatches++;
        return;
      end
      want = levels_due.pop_front();
      checked++;
      if (got.level !== want.level || got.end_of_row !== want.end_of_row ||
          got.end_of_frame !== want.end_of_frame) begin
        if (mismatches < 10)
          $display("ERROR: beat %0d: level %0d/%0d eor %0b/%0b eof %0b/%0b (expected/actual)",
                   checked, want.level, got.level, want.end_of_row, got.end_of_row,
                   want.end_of_frame, got.end_of_frame);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  fsd_pkg::fsd_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  fsd_pkg::fsd_out_t              out_data;

  dither_checker    chk = new();
  int unsigned      cycles = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      settings_loaded = 0;
  fsd_pkg::fsd_in_t last_px = '0;

  floyd_steinberg_dither_3bit_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL floyd_steinberg_dither_3bit_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.match_level(out_data);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(0, 31));
      3: return 8'($urandom_range(224, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // Repeated pixels make flat areas, where the diffused error matters most.
  function automatic fsd_pkg::fsd_in_t rand_pixel();
    if ($urandom_range(0, 99) >= 30) begin
      last_px.byte0 = pick_byte();
      last_px.byte1 = pick_byte();
      last_px.byte2 = pick_byte();
    end
    return last_px;
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 47;
      end
      1: begin
        send_idle_pct = 47;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_pixel(input fsd_pkg::fsd_in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_pixel(px);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [fsd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [fsd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    chk.write_reg(idx, val);
  endtask

  // The one-bit registers get random upper data bits, which must be ignored.
  task automatic load_settings(input logic [11:0] w, input logic [11:0] h,
                               input bit rgb, input bit inv);
    put_reg(fsd_pkg::REG_ROW_WIDTH, w);
    put_reg(fsd_pkg::REG_FRAME_HEIGHT, h);
    put_reg(fsd_pkg::REG_PIXEL_FORMAT, {11'($urandom), rgb});
    put_reg(fsd_pkg::REG_INVERT, {11'($urandom), inv});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // Shrinking width and height mid-frame makes the next beat close the frame,
  // so a new width never reads error entries the old rows did not write.
  task automatic close_frame();
    wait_drained();
    if (!chk.at_frame_start()) begin
      load_settings(12'd1, 12'd1, chk.pix_rgb, chk.inv_px);
      send_pixel(rand_pixel());
      wait_drained();
    end
  endtask

  task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input bit rgb,
                           input bit inv, input int unsigned n, input int mode);
    set_idle(mode);
    load_settings(w, h, rgb, inv);
    repeat (n) send_pixel(rand_pixel());
    close_frame();
  endtask

  initial begin
    logic [7:0]       gray_run [12];
    fsd_pkg::fsd_in_t px;
    gray_run = '{8'd0, 8'd255, 8'd31, 8'd32, 8'd255, 8'd224, 8'd127, 8'd128,
                 8'd250, 8'd1, 8'd96, 8'd255};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a small gray frame with saturation, edges, first and last rows.
    set_idle(0);
    load_settings(12'd4, 12'd3, 1'b0, 1'b0);
    foreach (gray_run[i]) begin
      px.byte0 = gray_run[i];
      px.byte1 = 8'($urandom);
      px.byte2 = 8'($urandom);
      send_pixel(px);
    end
    wait_drained();

    // Single-column inverted RGB frame.
    load_settings(12'd1, 12'd2, 1'b1, 1'b1);
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    wait_drained();

    // Stop partway into the second row so the shrink clamps the column.
    load_settings(12'd6, 12'd2, 1'b1, 1'b0);
    repeat (10) send_pixel(rand_pixel());
    close_frame();

    run_phase(12'd5,    12'd3,    1'b0, 1'b0, 30,   0);
    run_phase(12'd17,   12'd4,    1'b1, 1'b0, 36,   0);
    run_phase(12'd0,    12'd4095, 1'b0, 1'b1, 20,   0);
    run_phase(12'd2,    12'd0,    1'b1, 1'b1, 16,   0);
    run_phase(12'd1024, 12'd2,    1'b1, 1'b1, 1028, 1);
    run_phase(12'd9,    12'd6,    1'b0, 1'b1, 30,   1);
    run_phase(12'd1,    12'd1,    1'b0, 1'b0, 10,   1);
    run_phase(12'd33,   12'd3,    1'b1, 1'b1, 40,   1);
    run_phase(12'hFFF,  12'd3,    1'b0, 1'b0, 20,   2);
    run_phase(12'd3,    12'd4095, 1'b1, 1'b0, 20,   2);
    run_phase(12'd11,   12'd5,    1'b0, 1'b0, 30,   2);
    run_phase(12'd64,   12'd2,    1'b1, 1'b1, 66,   2);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d output beats across %0d register settings,", chk.checked,
             settings_loaded);
    $display("gray and RGB, both polarities, widths 1 to 1024, heights 1 to 4095.");
    if (chk.mismatches == 0 && chk.levels_due.size() == 0) begin
      $display("PASS floyd_steinberg_dither_3bit_core");
    end else begin
      $display("%0d mismatches, %0d beats still pending", chk.mismatches,
               chk.levels_due.size());
      $display("FAIL floyd_steinberg_dither_3bit_core");
    end
    $finish;
  end

endmodule
